// ===== design/mpab_pkg.sv =====
// Shared types, constants and a helper function for the masked pixel alpha blender.
package mpab_pkg;

  typedef enum logic [1:0] {
    REG_RED   = 2'd0,
    REG_GREEN = 2'd1,
    REG_BLUE  = 2'd2,
    REG_ALPHA = 2'd3
  } cfg_reg_t;

  localparam logic [31:0] RED_RESET   = 32'h00FF_0000;
  localparam logic [31:0] GREEN_RESET = 32'h0000_FF00;
  localparam logic [31:0] BLUE_RESET  = 32'h0000_00FF;
  localparam logic [31:0] ALPHA_RESET = 32'hFF00_0000;

  localparam logic [7:0]  ALPHA_FULL = 8'hFF;
  localparam logic [47:0] ROUND_HALF = 48'd32512;

  // Reciprocal of 65025 scaled by 2**64 and rounded up; exact for 48-bit dividends.
  localparam logic [48:0] RECIP = 49'h01_0203_0405_0608;

  typedef struct packed {
    logic mul;
    logic sum;
    logic pp;
    logic quo;
  } chan_en_t;

  function automatic logic [5:0] tz_count(input logic [31:0] m);
    logic [31:0] low;
    logic [5:0]  c;
    low = m & (~m + 32'd1);
    c   = 6'd32;
    if (low != 32'd0) c = c - 6'd1;
    if ((low & 32'h0000_FFFF) != 32'd0) c = c - 6'd16;
    if ((low & 32'h00FF_00FF) != 32'd0) c = c - 6'd8;
    if ((low & 32'h0F0F_0F0F) != 32'd0) c = c - 6'd4;
    if ((low & 32'h3333_3333) != 32'd0) c = c - 6'd2;
    if ((low & 32'h5555_5555) != 32'd0) c = c - 6'd1;
    return c;
  endfunction

endpackage

// ===== design/mpab_chan.sv =====
// Per-channel blend datapath: weighted sum, rounded division by 65025, clip and placement.
module mpab_chan
  import mpab_pkg::*;
(
  input  logic        clk,
  input  chan_en_t    en,
  input  logic [31:0] dval,
  input  logic [31:0] sval,
  input  logic [15:0] wa,
  input  logic [15:0] wb,
  input  logic [5:0]  shift,
  input  logic [31:0] maxv,
  input  logic [31:0] mask,
  output logic [31:0] part
);

  localparam logic [24:0] RECIP_HI = RECIP[48:24];
  localparam logic [23:0] RECIP_LO = RECIP[23:0];

  logic [47:0] pa;
  logic [47:0] pb;
  logic [47:0] x;
  logic [48:0] p_hh;
  logic [47:0] p_hl;
  logic [48:0] p_lh;
  logic [47:0] p_ll;
  logic [32:0] q;

  logic [48:0] x_sum;
  logic [49:0] mid;
  logic [96:0] acc;
  logic [31:0] q_sat;

  assign x_sum = {1'b0, pa} + {1'b0, pb} + {1'b0, ROUND_HALF};
  assign mid   = {2'b00, p_hl} + {1'b0, p_lh};
  assign acc   = {p_hh, 48'd0} + {23'd0, mid, 24'd0} + {49'd0, p_ll};

  always_ff @(posedge clk) begin
    if (en.mul) begin
      pa <= {16'd0, dval} * {32'd0, wa};
      pb <= {16'd0, sval} * {32'd0, wb};
    end
    if (en.sum) begin
      x <= x_sum[47:0];
    end
    if (en.pp) begin
      p_hh <= {25'd0, x[47:24]} * {24'd0, RECIP_HI};
      p_hl <= {24'd0, x[47:24]} * {24'd0, RECIP_LO};
      p_lh <= {25'd0, x[23:0]} * {24'd0, RECIP_HI};
      p_ll <= {24'd0, x[23:0]} * {24'd0, RECIP_LO};
    end
    if (en.quo) begin
      q <= acc[96:64];
    end
  end

  assign q_sat = (q > {1'b0, maxv}) ? maxv : q[31:0];
  assign part  = (q_sat << shift) & mask;

endmodule

// ===== design/masked_pixel_alpha_blend.sv =====
// Top level of the masked pixel alpha blender: configuration, pipeline control and channel lanes.
// Eight register stages: pixel, unpack, weight, product, sum, partial product, quotient, output.
// Throughput: one word per cycle unless stalled; a stage advances if empty or the next advances.
// The division by 65025 is a reciprocal multiply split into four partial products.
// Reset: rst is synchronous and active high; it empties the pipeline and restores the
// default red, green, blue and alpha masks.
module masked_pixel_alpha_blend
  import mpab_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        pair_valid,
  output logic        pair_stall,
  input  logic [31:0] dest_pixel,
  input  logic [31:0] src_pixel,
  output logic        blend_valid,
  input  logic        blend_stall,
  output logic [31:0] blended_pixel,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] mask  [4];
  logic [5:0]  shift [4];
  logic [31:0] maxv  [3];

  logic [7:0]  vld;
  logic [7:0]  en;

  logic [31:0] px_d;
  logic [31:0] px_s;
  logic [31:0] dval1 [3];
  logic [31:0] sval1 [3];
  logic [7:0]  da1;
  logic [7:0]  sa1;
  logic [31:0] dval2 [3];
  logic [31:0] sval2 [3];
  logic [15:0] wa2;
  logic [15:0] wb2;

  logic [31:0] a_d;
  logic [31:0] a_s;
  logic [31:0] part [3];
  chan_en_t    chan_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask[0] <= RED_RESET;
      mask[1] <= GREEN_RESET;
      mask[2] <= BLUE_RESET;
      mask[3] <= ALPHA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RED:   mask[0] <= cfg_data;
        REG_GREEN: mask[1] <= cfg_data;
        REG_BLUE:  mask[2] <= cfg_data;
        REG_ALPHA: mask[3] <= cfg_data;
        default:   mask[0] <= mask[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      shift[i] <= tz_count(mask[i]);
    end
    for (int i = 0; i < 3; i++) begin
      maxv[i] <= mask[i] >> tz_count(mask[i]);
    end
  end

  always_comb begin
    en[7] = !vld[7] || !blend_stall;
    for (int k = 6; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign pair_stall  = !en[0];
  assign blend_valid = vld[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= pair_valid;
      for (int k = 1; k < 8; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign a_d = (px_d & mask[3]) >> shift[3];
  assign a_s = (px_s & mask[3]) >> shift[3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      px_d <= dest_pixel;
      px_s <= src_pixel;
    end
    if (en[1]) begin
      for (int c = 0; c < 3; c++) begin
        dval1[c] <= (px_d & mask[c]) >> shift[c];
        sval1[c] <= (px_s & mask[c]) >> shift[c];
      end
      da1 <= (a_d > {24'd0, ALPHA_FULL}) ? ALPHA_FULL : a_d[7:0];
      sa1 <= (a_s > {24'd0, ALPHA_FULL}) ? ALPHA_FULL : a_s[7:0];
    end
    if (en[2]) begin
      dval2 <= dval1;
      sval2 <= sval1;
      wa2   <= {8'd0, da1} * {8'd0, ALPHA_FULL - sa1};
      wb2   <= {8'd0, sa1} * {8'd0, ALPHA_FULL};
    end
    if (en[7]) begin
      blended_pixel <= mask[3] | part[0] | part[1] | part[2];
    end
  end

  assign chan_en.mul = en[3];
  assign chan_en.sum = en[4];
  assign chan_en.pp  = en[5];
  assign chan_en.quo = en[6];

  for (genvar c = 0; c < 3; c++) begin : g_chan
    mpab_chan u_chan (
      .clk   (clk),
      .en    (chan_en),
      .dval  (dval2[c]),
      .sval  (sval2[c]),
      .wa    (wa2),
      .wb    (wb2),
      .shift (shift[c]),
      .maxv  (maxv[c]),
      .mask  (mask[c]),
      .part  (part[c])
    );
  end

endmodule

// ===== design/mpab_checker.sv =====
// Port-level checker for the masked pixel alpha blender and its bind statement.
module mpab_checker
  import mpab_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        pair_stall,
  input logic        blend_valid,
  input logic        blend_stall,
  input logic [31:0] blended_pixel,
  input logic        cfg_we,
  input logic [1:0]  cfg_index,
  input logic [31:0] cfg_data
);

  logic [31:0] alpha_shadow;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_shadow <= ALPHA_RESET;
    end else if (cfg_we && cfg_index == REG_ALPHA) begin
      alpha_shadow <= cfg_data;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !blend_valid)
    else $error("output word valid right after reset");

  a_alpha_set: assert property (@(posedge clk) disable iff (rst)
    blend_valid |-> (blended_pixel & alpha_shadow) == alpha_shadow)
    else $error("alpha mask bits not fully set in output word");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    pair_stall |-> blend_valid && blend_stall)
    else $error("input stalled while output side is not blocked");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    blend_valid && blend_stall |=> blend_valid && $stable(blended_pixel))
    else $error("stalled output word changed or dropped");

endmodule

bind masked_pixel_alpha_blend mpab_checker u_checker (.*);
